@@ hdl/text_console_cell_writer_macros.svh @@
// assertion macros shared by the console writer rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ctc_pkg.sv @@
// types and constants for the text console cell writer
// no dependencies; used by text_console_cell_writer
package ctc_pkg;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int PROD_W  = ROW_W + COL_W;
    localparam int CELL_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // actions
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_HEX   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ATTR   = 2'd2;

    localparam logic [COL_W-1:0] WIDTH_RST  = 7'd80;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 5'd25;
    localparam logic [7:0]       ATTR_RST   = 8'h07;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam int         NIBBLES      = 8;

    localparam logic [7:0] HEX_GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [31:0] hex_word;
        logic [10:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_value;
    } rsp_t;

endpackage

@@ hdl/text_console_cell_writer.sv @@
// text console: cell store in one ram, cursor and sweep control in a small fsm
// a scrolling newline moves rows 1 to height-1 up one row, one cell copied per cycle
// throughput set by the single ram write port: one cell write per cycle
// reset: async, active low; afterwards a pass fills all MAX_COLS*MAX_ROWS cells
// of the store with spaces in attribute 07 before the first transaction is taken
`include "text_console_cell_writer_macros.svh"

module text_console_cell_writer
    import ctc_pkg::*;
#(
    parameter int MAX_COLS = 80,
    parameter int MAX_ROWS = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_CLEAR,
        S_RDATA,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  width_reg, width_next;
    logic [ROW_W-1:0]  height_reg, height_next;
    logic [7:0]        attr_reg, attr_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    cmd_t              cmd_reg, cmd_next;
    logic [31:0]       word_reg, word_next;
    logic [2:0]        nib_reg, nib_next;
    logic [7:0]        fill_reg, fill_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [PROD_W-1:0] src_reg, src_next;
    logic [PROD_W-1:0] wa_reg, wa_next;
    logic              pend_reg, pend_next;
    logic [CELL_W-1:0] value_reg, value_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    logic              cfg_wr;
    logic [COL_W-1:0]  w_use;
    logic [ROW_W-1:0]  h_use;
    logic [ROW_W-1:0]  row_eff;
    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  row_inc;
    logic [COL_W-1:0]  col_inc;
    logic [PROD_W-1:0] put_idx;
    logic [PROD_W-1:0] span_end;
    logic [7:0]        put_ch;
    logic              put_last;
    logic              scroll_issue;
    logic              fin;
    logic [CELL_W-1:0] fin_value;
    logic              slot_free;
    logic              rsp_load;

    ctc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_ATTR:   prdata = PDATA_W'(attr_reg);
            default:    prdata = '0;
        endcase
    end

    // geometry in use, saturated to the store size, a zero taken as 1
    assign w_use = (width_reg == '0) ? COL_W'(1) :
                   ((32'(width_reg) > MAX_COLS) ? COL_W'(MAX_COLS) : width_reg);
    assign h_use = (height_reg == '0) ? ROW_W'(1) :
                   ((32'(height_reg) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : height_reg);

    // cursor pulled back inside the screen before a put
    assign row_eff  = (row_reg >= h_use) ? h_use - ROW_W'(1) : row_reg;
    assign col_eff  = (col_reg >= w_use) ? w_use - COL_W'(1) : col_reg;
    assign row_inc  = row_eff + ROW_W'(1);
    assign col_inc  = col_eff + COL_W'(1);
    assign put_idx  = PROD_W'(row_eff) * PROD_W'(w_use) + PROD_W'(col_eff);
    assign span_end = PROD_W'(h_use) * PROD_W'(w_use);

    assign put_ch   = (cmd_reg.action == ACT_HEX) ? HEX_GLYPHS[word_reg[31:28]] :
                                                    cmd_reg.char_code;
    assign put_last = (cmd_reg.action == ACT_PUT) || (nib_reg == 3'(NIBBLES - 1));
    assign scroll_issue = (src_reg < span_end);

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next  = state_reg;
        width_next  = width_reg;
        height_next = height_reg;
        attr_next   = attr_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cmd_next    = cmd_reg;
        word_next   = word_reg;
        nib_next    = nib_reg;
        fill_next   = fill_reg;
        clr_next    = clr_reg;
        src_next    = src_reg;
        wa_next     = wa_reg;
        pend_next   = 1'b0;
        value_next  = value_reg;
        rsp_next    = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(put_idx);
        ram_wdata   = {attr_reg, put_ch};
        ram_raddr   = ADDR_W'(cmd.cell_index);
        fin         = 1'b0;
        fin_value   = '0;
        rsp_load    = 1'b0;

        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WIDTH:  width_next  = pwdata[COL_W-1:0];
                REG_HEIGHT: height_next = pwdata[ROW_W-1:0];
                REG_ATTR:   attr_next   = pwdata[7:0];
                default:    ;
            endcase
        end

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {fill_reg, SPACE_CODE};
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    if (state_reg == S_INIT)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next = '0;
                        col_next = '0;
                        fin      = 1'b1;
                    end
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next  = cmd;
                    word_next = cmd.hex_word;
                    nib_next  = '0;
                    case (cmd.action)
                        ACT_PUT, ACT_HEX: state_next = S_PUT;
                        ACT_CLEAR:
                        begin
                            fill_next  = attr_reg;
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default: state_next = S_RDATA;
                    endcase
                end
            end
            S_PUT:
            begin
                if ((cmd_reg.action == ACT_PUT) && (put_ch == NEWLINE_CODE))
                begin
                    col_next = '0;
                    if (row_inc == h_use)
                    begin
                        row_next   = row_eff;
                        src_next   = PROD_W'(w_use);
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        row_next = row_inc;
                        fin      = 1'b1;
                    end
                end
                else
                begin
                    ram_we = 1'b1;
                    if (col_inc == w_use)
                    begin
                        col_next = '0;
                        row_next = (row_inc == h_use) ? '0 : row_inc;
                    end
                    else
                    begin
                        col_next = col_inc;
                        row_next = row_eff;
                    end
                    if (put_last)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        word_next = {word_reg[27:0], 4'h0};
                        nib_next  = nib_reg + 3'd1;
                    end
                end
            end
            S_SCROLL:
            begin
                // read cell a while the cell read last cycle lands at a - width
                ram_raddr = ADDR_W'(src_reg);
                ram_we    = pend_reg;
                ram_waddr = ADDR_W'(wa_reg);
                ram_wdata = ram_rdata;
                if (scroll_issue)
                begin
                    src_next  = src_reg + PROD_W'(1);
                    wa_next   = src_reg - PROD_W'(w_use);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    fin = 1'b1;
                end
            end
            S_RDATA:
            begin
                fin = 1'b1;
                if (32'(cmd_reg.cell_index) < CELL_COUNT)
                begin
                    fin_value = ram_rdata;
                end
            end
            S_DONE:
            begin
                fin       = 1'b1;
                fin_value = value_reg;
            end
            default: state_next = S_IDLE;
        endcase

        if (fin)
        begin
            if (slot_free)
            begin
                rsp_load       = 1'b1;
                rsp_valid_next = 1'b1;
                rsp_next       = '{cursor_row: row_next, cursor_col: col_next,
                                   cell_value: fin_value};
                state_next     = S_IDLE;
            end
            else
            begin
                value_next = fin_value;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            attr_reg      <= ATTR_RST;
            row_reg       <= '0;
            col_reg       <= '0;
            cmd_reg       <= '0;
            word_reg      <= '0;
            nib_reg       <= '0;
            fill_reg      <= ATTR_RST;
            clr_reg       <= '0;
            src_reg       <= '0;
            wa_reg        <= '0;
            pend_reg      <= 1'b0;
            value_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            attr_reg      <= attr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cmd_reg       <= cmd_next;
            word_reg      <= word_next;
            nib_reg       <= nib_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            src_reg       <= src_next;
            wa_reg        <= wa_next;
            pend_reg      <= pend_next;
            value_reg     <= value_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    `CTC_ASSERT_NOW(a_put_in_store, state_reg == S_PUT, 32'(put_idx) < CELL_COUNT, "put index beyond store")
    `CTC_ASSERT_NOW(a_scroll_order, (state_reg == S_SCROLL) && pend_reg, wa_reg < src_reg, "scroll write overtakes read")
    `CTC_ASSERT_NOW(a_load_free_slot, rsp_load, !rsp_valid_reg || rsp_ready, "result overwrites pending result")
    `CTC_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "transaction taken while busy")

endmodule

@@ hdl/ctc_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module ctc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
